// ===== hw/rtl/srsm_pkg.sv =====
// ----------------------------------------------------------------------------
// srsm_pkg
// Shared types and constants of the shadow return stack monitor.
// ----------------------------------------------------------------------------
package srsm_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W  = CNT_W + 1;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned OCC_W  = 7;
  localparam int unsigned STS_W  = 3;
  localparam int unsigned CMD_W  = 2;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [WORD_W:0]   wide_t;
  typedef logic [OCC_W-1:0]  occ_t;
  typedef logic [STS_W-1:0]  sts_t;
  typedef logic [CMD_W-1:0]  cmd_t;

  localparam cmd_t CMD_CALL   = 2'd0;
  localparam cmd_t CMD_RETURN = 2'd1;
  localparam cmd_t CMD_WCHECK = 2'd2;
  localparam cmd_t CMD_RANGE  = 2'd3;

  localparam sts_t ST_DONE          = 3'd0;
  localparam sts_t ST_EMPTY         = 3'd1;
  localparam sts_t ST_MISMATCH      = 3'd2;
  localparam sts_t ST_UNWOUND_MATCH = 3'd3;
  localparam sts_t ST_UNWOUND_EMPTY = 3'd4;
  localparam sts_t ST_DISABLED      = 3'd5;
  localparam sts_t ST_OVERFLOW      = 3'd6;

  localparam word_t RET_OFFSET = 32'd4;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_RET,
    FSM_SCAN,
    FSM_FLUSH
  } state_e;

  typedef enum logic [1:0] {
    SH_HOLD,
    SH_DOWN,
    SH_UP
  } shift_e;

  typedef struct packed {
    shift_e op;
    word_t  head;
    word_t  cmp_addr;
    cnt_t   count;
  } chain_ctrl_t;

  typedef struct packed {
    word_t top;
    word_t tail;
    logic  hit;
  } chain_stat_t;

endpackage

// ===== hw/rtl/srsm_cell.sv =====
// ----------------------------------------------------------------------------
// srsm_cell
// One stack slot: holds, takes its upper or lower neighbor, compares.
// ----------------------------------------------------------------------------
module srsm_cell (
  input  logic              clk_i,
  input  srsm_pkg::shift_e  op_i,
  input  srsm_pkg::word_t   from_prev_i,
  input  srsm_pkg::word_t   from_next_i,
  input  srsm_pkg::word_t   cmp_addr_i,
  output srsm_pkg::word_t   value_o,
  output logic              match_o
);

  srsm_pkg::word_t value_q, value_d;

  always_comb begin
    unique case (op_i)
      srsm_pkg::SH_DOWN: value_d = from_prev_i;
      srsm_pkg::SH_UP:   value_d = from_next_i;
      default:           value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign match_o = (value_q == cmp_addr_i);

endmodule

// ===== hw/rtl/srsm_chain.sv =====
// ----------------------------------------------------------------------------
// srsm_chain
// Row of slot cells, top of stack in cell 0, shifting as one.
// ----------------------------------------------------------------------------
module srsm_chain (
  input  logic                   clk_i,
  input  srsm_pkg::chain_ctrl_t  ctrl_i,
  output srsm_pkg::chain_stat_t  stat_o
);

  srsm_pkg::word_t               value [srsm_pkg::DEPTH];
  logic [srsm_pkg::DEPTH-1:0]    match;
  logic [srsm_pkg::DEPTH-1:0]    held;

  for (genvar i = 0; i < srsm_pkg::DEPTH; i++) begin : g_cell
    srsm_pkg::word_t prev_w, next_w;

    if (i == 0) begin : g_head
      assign prev_w = ctrl_i.head;
    end else begin : g_prev
      assign prev_w = value[i-1];
    end

    if (i == srsm_pkg::DEPTH - 1) begin : g_tail
      assign next_w = value[i];
    end else begin : g_next
      assign next_w = value[i+1];
    end

    srsm_cell u_cell (
      .clk_i       (clk_i),
      .op_i        (ctrl_i.op),
      .from_prev_i (prev_w),
      .from_next_i (next_w),
      .cmp_addr_i  (ctrl_i.cmp_addr),
      .value_o     (value[i]),
      .match_o     (match[i])
    );

    assign held[i] = (srsm_pkg::cnt_t'(i) < ctrl_i.count);
  end

  assign stat_o.top  = value[0];
  assign stat_o.tail = value[srsm_pkg::DEPTH-1];
  assign stat_o.hit  = |(match & held);

endmodule

// ===== hw/rtl/shadow_return_stack_monitor.sv =====
// ----------------------------------------------------------------------------
// shadow_return_stack_monitor
// Shadow stack of return addresses with call, return and address checks.
//
// Input items arrive on s_axis: tuser carries the command, tdata the stack
// pointer, the address and the range length. Results leave on m_axis, one
// per item except a range check, which gives one per slot in range, or a
// single result with hit clear when no slot is in range; tlast marks the
// final result of an item. cfg_we_i writes the enable bit. Call, write
// check, disabled and empty-return items give a result that is valid the
// cycle after acceptance. A return examines the slots at the top of the
// stack one at a time, since the slot row pops one entry per cycle while
// the output register is free, and reports an unwind to empty once the
// row is empty. A range check rotates the whole slot row past a single
// comparator whatever the occupancy. One item is in work at a time.
// Reset empties the stack and sets enable; slot contents are not cleared.
// When the receiver stalls, the result waits in the output register and
// the block holds all state until it is taken.
// ----------------------------------------------------------------------------
module shadow_return_stack_monitor (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [95:0]   s_axis_tdata,   // stack_ptr, addr, length
  input  logic [1:0]    s_axis_tuser,   // cmd
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [47:0]   m_axis_tdata,   // hit, slot_addr, popped, occupancy, pad
  output logic [2:0]    m_axis_tuser,   // status
  output logic          m_axis_tlast
);

  srsm_pkg::state_e      state_q, state_d;
  srsm_pkg::cnt_t        count_q, count_d;
  srsm_pkg::cnt_t        popped_q, popped_d;
  srsm_pkg::idx_t        scan_q, scan_d;
  srsm_pkg::word_t       sp_q, sp_d;
  srsm_pkg::word_t       lo_q, lo_d;
  srsm_pkg::wide_t       hi_q, hi_d;
  srsm_pkg::word_t       pend_val_q, pend_val_d;
  logic                  pend_vld_q, pend_vld_d;
  logic                  enable_q;

  logic                  out_valid_q;
  srsm_pkg::sts_t        out_status_q;
  logic                  out_hit_q;
  srsm_pkg::word_t       out_slot_q;
  srsm_pkg::occ_t        out_popped_q;
  srsm_pkg::occ_t        out_occ_q;
  logic                  out_last_q;

  logic                  emit;
  srsm_pkg::sts_t        res_status;
  logic                  res_hit;
  srsm_pkg::word_t       res_slot;
  srsm_pkg::cnt_t        res_popped;
  logic                  res_last;

  srsm_pkg::chain_ctrl_t chain_ctrl;
  srsm_pkg::chain_stat_t chain_stat;

  logic                  out_free;
  logic                  accept;
  srsm_pkg::cmd_t        in_cmd;
  srsm_pkg::word_t       in_sp;
  srsm_pkg::word_t       in_addr;
  srsm_pkg::word_t       in_len;
  logic                  scan_elig;
  logic                  scan_inr;

  assign in_cmd  = s_axis_tuser;
  assign in_sp   = s_axis_tdata[31:0];
  assign in_addr = s_axis_tdata[63:32];
  assign in_len  = s_axis_tdata[95:64];

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == srsm_pkg::FSM_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign scan_elig = (srsm_pkg::sum_t'(scan_q) + srsm_pkg::sum_t'(count_q))
                     >= srsm_pkg::sum_t'(srsm_pkg::DEPTH);
  assign scan_inr  = scan_elig && (chain_stat.tail >= lo_q) &&
                     ({1'b0, chain_stat.tail} < hi_q);

  srsm_chain u_chain (
    .clk_i  (clk_i),
    .ctrl_i (chain_ctrl),
    .stat_o (chain_stat)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      srsm_pkg::FSM_IDLE: begin
        if (accept) begin
          if (in_cmd == srsm_pkg::CMD_RANGE) begin
            state_d = srsm_pkg::FSM_SCAN;
          end else if (in_cmd == srsm_pkg::CMD_RETURN && enable_q &&
                       count_q != '0) begin
            state_d = srsm_pkg::FSM_RET;
          end
        end
      end
      srsm_pkg::FSM_RET: begin
        if (out_free && (count_q == '0 || chain_stat.top >= sp_q)) begin
          state_d = srsm_pkg::FSM_IDLE;
        end
      end
      srsm_pkg::FSM_SCAN: begin
        if (out_free && scan_q == srsm_pkg::idx_t'(srsm_pkg::DEPTH - 1)) begin
          state_d = srsm_pkg::FSM_FLUSH;
        end
      end
      srsm_pkg::FSM_FLUSH: begin
        if (out_free) begin
          state_d = srsm_pkg::FSM_IDLE;
        end
      end
      default: state_d = srsm_pkg::FSM_IDLE;
    endcase
  end

  // datapath control and results
  always_comb begin
    emit       = 1'b0;
    res_status = srsm_pkg::ST_DONE;
    res_hit    = 1'b0;
    res_slot   = '0;
    res_popped = '0;
    res_last   = 1'b1;
    count_d    = count_q;
    popped_d   = popped_q;
    scan_d     = scan_q;
    sp_d       = sp_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    pend_vld_d = pend_vld_q;
    pend_val_d = pend_val_q;
    chain_ctrl.op       = srsm_pkg::SH_HOLD;
    chain_ctrl.head     = in_sp - srsm_pkg::RET_OFFSET;
    chain_ctrl.cmp_addr = in_addr;
    chain_ctrl.count    = count_q;

    unique case (state_q)
      srsm_pkg::FSM_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            srsm_pkg::CMD_CALL: begin
              emit = 1'b1;
              if (!enable_q) begin
                res_status = srsm_pkg::ST_DISABLED;
              end else if (count_q == srsm_pkg::cnt_t'(srsm_pkg::DEPTH)) begin
                res_status = srsm_pkg::ST_OVERFLOW;
              end else begin
                chain_ctrl.op = srsm_pkg::SH_DOWN;
                count_d       = count_q + srsm_pkg::cnt_t'(1);
              end
            end
            srsm_pkg::CMD_RETURN: begin
              if (!enable_q) begin
                emit       = 1'b1;
                res_status = srsm_pkg::ST_DISABLED;
              end else if (count_q == '0) begin
                emit       = 1'b1;
                res_status = srsm_pkg::ST_EMPTY;
              end else begin
                sp_d     = in_sp;
                popped_d = '0;
              end
            end
            srsm_pkg::CMD_WCHECK: begin
              emit     = 1'b1;
              res_hit  = chain_stat.hit;
              res_slot = chain_stat.hit ? in_addr : '0;
            end
            srsm_pkg::CMD_RANGE: begin
              lo_d       = in_addr;
              hi_d       = {1'b0, in_addr} + {1'b0, in_len};
              scan_d     = '0;
              pend_vld_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      srsm_pkg::FSM_RET: begin
        if (out_free) begin
          res_popped = popped_q;
          if (count_q == '0) begin
            emit       = 1'b1;
            res_status = srsm_pkg::ST_UNWOUND_EMPTY;
          end else if (chain_stat.top == sp_q) begin
            emit          = 1'b1;
            chain_ctrl.op = srsm_pkg::SH_UP;
            count_d       = count_q - srsm_pkg::cnt_t'(1);
            popped_d      = popped_q + srsm_pkg::cnt_t'(1);
            res_popped    = popped_d;
            res_status    = (popped_q == '0) ? srsm_pkg::ST_DONE
                                             : srsm_pkg::ST_UNWOUND_MATCH;
          end else if (chain_stat.top > sp_q) begin
            emit       = 1'b1;
            res_status = srsm_pkg::ST_MISMATCH;
          end else begin
            chain_ctrl.op = srsm_pkg::SH_UP;
            count_d       = count_q - srsm_pkg::cnt_t'(1);
            popped_d      = popped_q + srsm_pkg::cnt_t'(1);
          end
        end
      end
      srsm_pkg::FSM_SCAN: begin
        chain_ctrl.head = chain_stat.tail;
        if (out_free) begin
          chain_ctrl.op = srsm_pkg::SH_DOWN;
          scan_d        = scan_q + srsm_pkg::idx_t'(1);
          if (scan_inr) begin
            pend_vld_d = 1'b1;
            pend_val_d = chain_stat.tail;
            if (pend_vld_q) begin
              emit     = 1'b1;
              res_hit  = 1'b1;
              res_slot = pend_val_q;
              res_last = 1'b0;
            end
          end
        end
      end
      srsm_pkg::FSM_FLUSH: begin
        if (out_free) begin
          emit     = 1'b1;
          res_hit  = pend_vld_q;
          res_slot = pend_vld_q ? pend_val_q : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srsm_pkg::FSM_IDLE;
      count_q     <= '0;
      enable_q    <= 1'b1;
      out_valid_q <= 1'b0;
      pend_vld_q  <= 1'b0;
      popped_q    <= '0;
      scan_q      <= '0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      pend_vld_q <= pend_vld_d;
      popped_q   <= popped_d;
      scan_q     <= scan_d;
      if (cfg_we_i) begin
        enable_q <= cfg_wdata_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sp_q       <= sp_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    pend_val_q <= pend_val_d;
    if (emit) begin
      out_status_q <= res_status;
      out_hit_q    <= res_hit;
      out_slot_q   <= res_slot;
      out_popped_q <= srsm_pkg::occ_t'(res_popped);
      out_occ_q    <= srsm_pkg::occ_t'(count_d);
      out_last_q   <= res_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {1'b0, out_occ_q, out_popped_q, out_slot_q, out_hit_q};

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= srsm_pkg::cnt_t'(srsm_pkg::DEPTH))
    else $error("stack occupancy above depth");

  a_push_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_cmd == srsm_pkg::CMD_CALL && enable_q &&
     count_q != srsm_pkg::cnt_t'(srsm_pkg::DEPTH))
    |=> count_q == $past(count_q) + srsm_pkg::cnt_t'(1))
    else $error("call did not push");

  a_scan_keeps_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == srsm_pkg::FSM_SCAN || state_q == srsm_pkg::FSM_FLUSH)
    |=> $stable(count_q))
    else $error("range check changed occupancy");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !emit)
    else $error("result overwritten while stalled");

endmodule
